/* rtl/imu_tilt_pkg.sv */
`default_nettype none
package imu_tilt_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ANGLE_MAX = 23040;
    localparam int ZW        = 26;
    localparam int CW        = 33;
    // Blend steps per angle: mix, add, write back; pitch then roll.
    localparam int BLEND_STEPS = 6;

    localparam logic [1:0] REG_BLEND = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_LOW   = 2'd2;
    localparam logic [1:0] REG_HIGH  = 2'd3;

    localparam logic [1:0] LEVEL_OK     = 2'd0;
    localparam logic [1:0] LEVEL_WARN   = 2'd1;
    localparam logic [1:0] LEVEL_SEVERE = 2'd2;

    // Datapath operation selected by the controller.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_SQRT   = 3'd2,
        OP_PREP   = 3'd3,
        OP_ROT    = 3'd4,
        OP_BLEND  = 3'd5,
        OP_FINISH = 3'd6
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
        logic       sel;
    } cmd_t;

    typedef struct packed {
        logic [15:0] blend_weight;
        logic [15:0] gyro_gain;
        logic [14:0] low_limit;
        logic [14:0] high_limit;
    } cfg_t;

    // round(atan(2^-i) degrees * 65536)
    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 26'd2949120;
            5'd1:  v = 26'd1740967;
            5'd2:  v = 26'd919879;
            5'd3:  v = 26'd466945;
            5'd4:  v = 26'd234379;
            5'd5:  v = 26'd117304;
            5'd6:  v = 26'd58666;
            5'd7:  v = 26'd29335;
            5'd8:  v = 26'd14668;
            5'd9:  v = 26'd7334;
            5'd10: v = 26'd3667;
            5'd11: v = 26'd1833;
            5'd12: v = 26'd917;
            5'd13: v = 26'd458;
            5'd14: v = 26'd229;
            5'd15: v = 26'd115;
            5'd16: v = 26'd57;
            5'd17: v = 26'd29;
            5'd18: v = 26'd14;
            5'd19: v = 26'd7;
            5'd20: v = 26'd4;
            5'd21: v = 26'd2;
            5'd22: v = 26'd1;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/imu_tilt_if.sv */
`default_nettype none
interface imu_tilt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [15:0] gyro_x;
    logic [15:0] gyro_y;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface imu_tilt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pitch_angle;
    logic [15:0] roll_angle;
    logic [1:0]  tilt_level;
    modport source (output valid, pitch_angle, roll_angle, tilt_level, input ready);
    modport sink (input valid, pitch_angle, roll_angle, tilt_level, output ready);
endinterface
`default_nettype wire

/* rtl/imu_tilt_ctrl.sv */
`default_nettype none
module imu_tilt_ctrl #(
    parameter int STEPS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output imu_tilt_pkg::cmd_t  cmd
);
    import imu_tilt_pkg::*;

    localparam int NSTEP = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SQRT   = 8'b0000_0010,
        S_PREP   = 8'b0000_0100,
        S_ROT    = 8'b0000_1000,
        S_BLEND  = 8'b0001_0000,
        S_FINISH = 8'b0010_0000,
        S_OUT    = 8'b0100_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;

    // The result register sits in the datapath; a new word is taken as soon as
    // the previous result has been handed over or is being taken this cycle.
    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            S_IDLE, S_OUT:
            begin
                if (state_reg == S_OUT && out_ready)
                begin
                    state_next = S_IDLE;
                end
                if (in_valid && in_ready)
                begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    cnt_next   = '0;
                    sel_next   = 1'b0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                cnt_next   = '0;
                state_next = (NSTEP == 0) ? S_BLEND : S_ROT;
            end
            S_ROT:
            begin
                cmd.op   = OP_ROT;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(NSTEP - 1))
                begin
                    cnt_next = '0;
                    if (sel_reg)
                    begin
                        state_next = S_BLEND;
                    end
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = S_PREP;
                    end
                end
            end
            S_BLEND:
            begin
                cmd.op   = OP_BLEND;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(BLEND_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_load_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> in_ready)
        else $error("load without ready");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
endmodule
`default_nettype wire

/* rtl/imu_tilt_dp.sv */
`default_nettype none
module imu_tilt_dp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  imu_tilt_pkg::cmd_t  cmd,
    input  imu_tilt_pkg::cfg_t  cfg,
    input  wire  [15:0]         accel_x,
    input  wire  [15:0]         accel_y,
    input  wire  [15:0]         accel_z,
    input  wire  [15:0]         gyro_x,
    input  wire  [15:0]         gyro_y,
    output logic [15:0]         pitch_angle,
    output logic [15:0]         roll_angle,
    output logic [1:0]          tilt_level
);
    import imu_tilt_pkg::*;

    // Blend cycle within one angle.
    localparam logic [1:0] BL_MIX   = 2'd0;
    localparam logic [1:0] BL_ADD   = 2'd1;
    localparam logic [1:0] BL_WRITE = 2'd2;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic signed [15:0] pitch_reg, roll_reg;
    logic [1:0]         level_reg;
    // isqrt state
    logic [32:0]        rem_reg;
    logic [16:0]        root_reg;
    // CORDIC state
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg, accp_reg;
    // blend state
    logic signed [49:0] sum_reg;
    logic signed [33:0] gp_reg;

    // Restoring square root, one result bit per cycle, MSB first.
    logic [4:0]         sq_i;
    logic [33:0]        trial;
    logic [32:0]        n_full;
    logic signed [31:0] ax_sq, az_sq;
    assign sq_i   = 5'd16 - cmd.idx;
    assign ax_sq  = ax_reg * ax_reg;
    assign az_sq  = az_reg * az_reg;
    assign n_full = {1'b0, ax_sq} + {1'b0, az_sq};
    assign trial  = 34'(({17'd0, root_reg} << (sq_i + 5'd1))) + (34'd1 << (2 * sq_i));

    // CORDIC vector preparation
    logic signed [CW-1:0] vx, vy;
    logic                 vzero;
    always_comb
    begin
        if (!cmd.sel)
        begin
            vx = CW'($signed({1'b0, root_reg})) <<< 12;
            vy = CW'(ay_reg) <<< 12;
        end
        else
        begin
            vx = CW'(az_reg) <<< 12;
            vy = -(CW'(ax_reg) <<< 12);
        end
        vzero = (vx == '0) && (vy == '0);
    end

    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = y_reg >>> cmd.idx;
    assign dy = x_reg >>> cmd.idx;
    assign at = $signed(atan_entry(cmd.idx));

    // Blend: pitch in steps 0 to 2, roll in steps 3 to 5. The roll angle is
    // still in the rotator's angle register at this point.
    logic               blend_roll;
    logic [1:0]         blend_ph;
    logic signed [15:0] est_s, g_s;
    logic signed [ZW-1:0] acc_s;
    logic signed [17:0] wg_s, wa_s;
    logic signed [33:0] gp_mix;
    logic signed [43:0] acc_prod;
    logic signed [51:0] gp_prod;
    assign blend_roll = (cmd.idx >= 5'd3);
    assign blend_ph   = blend_roll ? 2'(cmd.idx - 5'd3) : cmd.idx[1:0];
    assign est_s = blend_roll ? roll_reg : pitch_reg;
    assign g_s   = blend_roll ? gx_reg : gy_reg;
    assign acc_s = blend_roll ? z_reg : accp_reg;
    assign wg_s  = $signed({2'b00, cfg.blend_weight});
    assign wa_s  = 18'sh10000 - wg_s;
    assign gp_mix   = est_s * 34'sd512 + g_s * $signed({18'd0, cfg.gyro_gain});
    assign acc_prod = acc_s * wa_s;
    assign gp_prod  = gp_reg * wg_s;

    logic signed [49:0] rnd;
    logic signed [25:0] rsh;
    logic signed [15:0] sat;
    assign rnd = sum_reg + (50'sd1 <<< 24);
    assign rsh = 26'(rnd >>> 25);
    always_comb
    begin
        if (rsh > 26'sd23040)
            sat = 16'sd23040;
        else if (rsh < -26'sd23040)
            sat = -16'sd23040;
        else
            sat = rsh[15:0];
    end

    logic [15:0] abs_p, abs_r;
    assign abs_p = pitch_reg[15] ? 16'(-pitch_reg) : pitch_reg;
    assign abs_r = roll_reg[15] ? 16'(-roll_reg) : roll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= '0;
            roll_reg  <= '0;
            level_reg <= LEVEL_OK;
        end
        else
        begin
            unique case (cmd.op)
                OP_BLEND:
                begin
                    if (blend_ph == BL_WRITE)
                    begin
                        if (blend_roll)
                            roll_reg <= sat;
                        else
                            pitch_reg <= sat;
                    end
                end
                OP_FINISH:
                begin
                    if (abs_p < {1'b0, cfg.low_limit} && abs_r < {1'b0, cfg.low_limit})
                        level_reg <= LEVEL_OK;
                    else if (abs_p > {1'b0, cfg.high_limit} || abs_r > {1'b0, cfg.high_limit})
                        level_reg <= LEVEL_SEVERE;
                    else
                        level_reg <= LEVEL_WARN;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The accelerometer term and the gyro path are formed in the mix step, the
    // weighted gyro path is added in the add step, and the rounded and clamped
    // angle is written back in the write step.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                ax_reg <= accel_x;
                ay_reg <= accel_y;
                az_reg <= accel_z;
                gx_reg <= gyro_x;
                gy_reg <= gyro_y;
            end
            OP_SQRT:
            begin
                if (cmd.idx == 5'd0)
                begin
                    rem_reg  <= n_full;
                    root_reg <= '0;
                end
                else if ({1'b0, rem_reg} >= trial)
                begin
                    rem_reg  <= 33'({1'b0, rem_reg} - trial);
                    root_reg <= root_reg | (17'd1 << sq_i);
                end
            end
            OP_PREP:
            begin
                if (vzero || vx >= 0)
                begin
                    x_reg <= vx;
                    y_reg <= vy;
                    z_reg <= '0;
                end
                else if (vy >= 0)
                begin
                    x_reg <= vy;
                    y_reg <= -vx;
                    z_reg <= ZW'(90 * 65536);
                end
                else
                begin
                    x_reg <= -vy;
                    y_reg <= vx;
                    z_reg <= -ZW'(90 * 65536);
                end
                if (cmd.sel)
                    accp_reg <= z_reg;
            end
            OP_ROT:
            begin
                if (y_reg == '0 && x_reg == '0)
                begin
                    z_reg <= z_reg;
                end
                else if (y_reg >= 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
            end
            OP_BLEND:
            begin
                if (blend_ph == BL_MIX)
                begin
                    gp_reg  <= gp_mix;
                    sum_reg <= 50'(acc_prod);
                end
                else if (blend_ph == BL_ADD)
                begin
                    sum_reg <= sum_reg + 50'(gp_prod);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;
    assign tilt_level  = level_reg;
endmodule
`default_nettype wire

/* rtl/imu_tilt_complementary_filter.sv */
`default_nettype none
// Tilt estimator with a complementary filter.
// Input channel: one word per IMU sample (three accelerometer axes and the
// gyro X and Y rates). Output channel: one word per sample with the filtered
// pitch and roll in 1/128 degree and a tilt class.
// After the input word is accepted, the result word is formed in this order:
// an iterative square root, two CORDIC passes through one shared rotator
// (each a set-up step and CORDIC_STEPS rotations, capped at TABLE_LEN = 24),
// the blend steps for pitch then roll, and a classification step.
// One sample is worked on at a time; the next word can be accepted at the
// edge that takes the result.
// If the receiver stalls, the result is held and no new word is accepted.
// Reset clears the stored estimates to zero and loads the register defaults.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12:
// blend weight, gyro gain, low limit and high limit.
module imu_tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    imu_tilt_in_if.sink  in_ch,
    imu_tilt_out_if.source out_ch,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import imu_tilt_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blend_weight <= 16'd29491;
            cfg_reg.gyro_gain    <= 16'd936;
            cfg_reg.low_limit    <= 15'd3840;
            cfg_reg.high_limit   <= 15'd6400;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_BLEND: cfg_reg.blend_weight <= pwdata[15:0];
                REG_GAIN:  cfg_reg.gyro_gain    <= pwdata[15:0];
                REG_LOW:   cfg_reg.low_limit    <= pwdata[14:0];
                REG_HIGH:  cfg_reg.high_limit   <= pwdata[14:0];
                default:   cfg_reg.gyro_gain    <= cfg_reg.gyro_gain;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BLEND: prdata = {16'd0, cfg_reg.blend_weight};
            REG_GAIN:  prdata = {16'd0, cfg_reg.gyro_gain};
            REG_LOW:   prdata = {17'd0, cfg_reg.low_limit};
            REG_HIGH:  prdata = {17'd0, cfg_reg.high_limit};
            default:   prdata = '0;
        endcase
    end

    imu_tilt_ctrl #(.STEPS(CORDIC_STEPS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    imu_tilt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg_reg),
        .accel_x     (in_ch.accel_x),
        .accel_y     (in_ch.accel_y),
        .accel_z     (in_ch.accel_z),
        .gyro_x      (in_ch.gyro_x),
        .gyro_y      (in_ch.gyro_y),
        .pitch_angle (out_ch.pitch_angle),
        .roll_angle  (out_ch.roll_angle),
        .tilt_level  (out_ch.tilt_level)
    );
endmodule
`default_nettype wire
